>>> design/swp_pkg.sv
// shared types and constants for the sliding window percentile block
package swp_pkg;

   // transaction kind codes
   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // percentile slots: median, p90, p99, max
   localparam int NUM_PCT = 4;
   localparam int PCT_MUL_W = 7;
   localparam logic [NUM_PCT-1:0][PCT_MUL_W-1:0] PCT_MUL = '{
      7'd100, 7'd99, 7'd90, 7'd50
   };
   localparam int PCT_MEDIAN = 0;
   localparam int PCT_P90    = 1;
   localparam int PCT_P99    = 2;
   localparam int PCT_MAX    = 3;

   // reciprocal of 100, rounded up, exact floor for products below 2^20
   localparam int RECIP_W     = 20;
   localparam int RECIP_SHIFT = 26;
   localparam logic [RECIP_W-1:0] RECIP_100 = 20'd671089;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TGT_MUL,
      ST_TGT_DIV,
      ST_CAND,
      ST_LOAD,
      ST_SCAN,
      ST_CHECK,
      ST_DONE
   } seq_state_type;

   // controls from the sequencer to the datapath
   typedef struct packed {
      logic start;
      logic tgt_mul;
      logic tgt_div;
      logic rd_en;
      logic load_cand;
      logic count;
      logic check;
      logic done_load;
   } seq_ctl_type;

endpackage

>>> design/sliding_window_percentiles.sv
// top level: frame time ring, running totals and percentile query engine
// A record transaction is taken whenever the sequencer is idle. In a query a
// single compare unit ranks each stored sample against every stored sample,
// reading the ring through its one registered read port; an empty window
// goes straight to the result. The block takes no transaction during a
// query. A finished result is held in an output register, and records are
// taken while it waits to be collected.
module sliding_window_percentiles #(
   parameter int WINDOW = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [31:0] req_frame_time,
   input  logic [31:0] req_tick_time,
   input  logic [15:0] req_tick_count,
   input  logic [15:0] req_dropped_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [8:0]  rsp_sample_count,
   output logic [31:0] rsp_median_time,
   output logic [31:0] rsp_p90_time,
   output logic [31:0] rsp_p99_time,
   output logic [31:0] rsp_max_time,
   output logic [63:0] rsp_frames_total,
   output logic [63:0] rsp_ticks_total,
   output logic [63:0] rsp_dropped_total,
   output logic [63:0] rsp_tick_time_total
);

   localparam int AW = $clog2(WINDOW);
   localparam int CW = $clog2(WINDOW + 1);
   localparam int YW = CW + swp_pkg::PCT_MUL_W;
   localparam int PW = YW + swp_pkg::RECIP_W;

   logic [31:0]   ring_mem [WINDOW];
   logic [31:0]   rd_data_ff;
   logic [AW-1:0] write_slot_ff;
   logic [CW-1:0] count_ff;
   logic [63:0]   tick_time_sum_ff;
   logic [63:0]   tick_sum_ff;
   logic [63:0]   dropped_sum_ff;
   logic [63:0]   frame_sum_ff;

   logic          seq_idle;
   logic [AW-1:0] rd_addr;
   logic          rec_fire;
   logic          qry_fire;
   logic          rsp_valid_ff;
   logic          rsp_free;
   swp_pkg::seq_ctl_type seq_ctl;

   logic [CW-1:0] last_idx;
   logic [swp_pkg::NUM_PCT-1:0][YW-1:0] tgt_prod_ff;
   logic [swp_pkg::NUM_PCT-1:0][CW-1:0] tgt_ff;
   logic [swp_pkg::NUM_PCT-1:0][PW-1:0] tgt_scaled;
   logic [swp_pkg::NUM_PCT-1:0][31:0]   pct;
   logic [CW+8:0] count_ext;

   assign req_ready = seq_idle;
   assign rec_fire  = req_valid && req_ready && (req_kind == swp_pkg::KIND_RECORD);
   assign qry_fire  = req_valid && req_ready && (req_kind == swp_pkg::KIND_QUERY);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // ring memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (rec_fire) begin
         ring_mem[write_slot_ff] <= req_frame_time;
      end
      if (seq_ctl.rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   // write pointer, saturating sample count and wrapping totals
   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff    <= '0;
         count_ff         <= '0;
         tick_time_sum_ff <= '0;
         tick_sum_ff      <= '0;
         dropped_sum_ff   <= '0;
         frame_sum_ff     <= '0;
      end else if (rec_fire) begin
         write_slot_ff    <= (write_slot_ff == AW'(WINDOW - 1)) ? '0 : write_slot_ff + AW'(1);
         if (count_ff != CW'(WINDOW)) begin
            count_ff <= count_ff + CW'(1);
         end
         tick_time_sum_ff <= tick_time_sum_ff + {32'd0, req_tick_time};
         tick_sum_ff      <= tick_sum_ff + {48'd0, req_tick_count};
         dropped_sum_ff   <= dropped_sum_ff + {48'd0, req_dropped_count};
         frame_sum_ff     <= frame_sum_ff + 64'd1;
      end
   end

   // target positions: (n-1)*pct, then divide by 100 via reciprocal
   assign last_idx = count_ff - CW'(1);

   always_comb begin
      for (int t = 0; t < swp_pkg::NUM_PCT; t++) begin
         tgt_scaled[t] = PW'(tgt_prod_ff[t]) * PW'(swp_pkg::RECIP_100);
      end
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t < swp_pkg::NUM_PCT; t++) begin
         if (seq_ctl.tgt_mul) begin
            tgt_prod_ff[t] <= YW'(last_idx) * YW'(swp_pkg::PCT_MUL[t]);
         end
         if (seq_ctl.tgt_div) begin
            tgt_ff[t] <= tgt_scaled[t][swp_pkg::RECIP_SHIFT +: CW];
         end
      end
   end

   swp_seq #(
      .AW (AW),
      .CW (CW)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (qry_fire),
      .count    (count_ff),
      .rsp_free (rsp_free),
      .idle     (seq_idle),
      .rd_addr  (rd_addr),
      .ctl      (seq_ctl)
   );

   swp_rank_unit #(
      .CW (CW)
   ) u_rank (
      .clock   (clock),
      .ctl     (seq_ctl),
      .rd_data (rd_data_ff),
      .tgt     (tgt_ff),
      .pct     (pct)
   );

   // result register
   assign count_ext = {9'd0, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_ctl.done_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_ctl.done_load) begin
         rsp_sample_count    <= count_ext[8:0];
         rsp_median_time     <= pct[swp_pkg::PCT_MEDIAN];
         rsp_p90_time        <= pct[swp_pkg::PCT_P90];
         rsp_p99_time        <= pct[swp_pkg::PCT_P99];
         rsp_max_time        <= pct[swp_pkg::PCT_MAX];
         rsp_frames_total    <= frame_sum_ff;
         rsp_ticks_total     <= tick_sum_ff;
         rsp_dropped_total   <= dropped_sum_ff;
         rsp_tick_time_total <= tick_time_sum_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a query holds off further transactions on the following cycle
   assert property (@(posedge clock) disable iff (reset) qry_fire |=> !req_ready)
      else $error("input accepted right after a query start");

   // a result appears only when the sequencer hands one over
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(seq_ctl.done_load))
      else $error("result valid without sequencer completion");

   // sample count saturates at the window depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(WINDOW))
      else $error("sample count above window depth");

   // no hand-over while a previous result still waits
   assert property (@(posedge clock) disable iff (reset)
      seq_ctl.done_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

endmodule

>>> design/swp_rank_unit.sv
// shared compare unit: ranks one candidate against all samples and captures hits
module swp_rank_unit #(
   parameter int CW = 9
) (
   input  logic                                          clock,
   input  swp_pkg::seq_ctl_type                          ctl,
   input  logic [31:0]                                   rd_data,
   input  logic [swp_pkg::NUM_PCT-1:0][CW-1:0]           tgt,
   output logic [swp_pkg::NUM_PCT-1:0][31:0]             pct
);

   logic [31:0]   cand_ff;
   logic [CW-1:0] lt_cnt_ff;
   logic [CW-1:0] le_cnt_ff;
   logic [swp_pkg::NUM_PCT-1:0][31:0] pct_ff;

   // candidate load and rank counting
   always_ff @(posedge clock) begin
      if (ctl.load_cand) begin
         cand_ff   <= rd_data;
         lt_cnt_ff <= '0;
         le_cnt_ff <= '0;
      end else if (ctl.count) begin
         if (rd_data < cand_ff) begin
            lt_cnt_ff <= lt_cnt_ff + CW'(1);
         end
         if (rd_data <= cand_ff) begin
            le_cnt_ff <= le_cnt_ff + CW'(1);
         end
      end
   end

   // candidate holds sorted position k when lt <= k < le
   always_ff @(posedge clock) begin
      for (int t = 0; t < swp_pkg::NUM_PCT; t++) begin
         if (ctl.start) begin
            pct_ff[t] <= '0;
         end else if (ctl.check && (lt_cnt_ff <= tgt[t]) && (tgt[t] < le_cnt_ff)) begin
            pct_ff[t] <= cand_ff;
         end
      end
   end

   assign pct = pct_ff;

endmodule

>>> design/swp_seq.sv
// query sequencer: walks candidates and samples through the shared compare unit
module swp_seq #(
   parameter int AW = 8,
   parameter int CW = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CW-1:0]        count,
   input  logic                 rsp_free,
   output logic                 idle,
   output logic [AW-1:0]        rd_addr,
   output swp_pkg::seq_ctl_type ctl
);

   swp_pkg::seq_state_type state_ff, state_in;
   logic [CW-1:0] cand_idx_ff, cand_idx_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic [CW-1:0] rd_idx;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= swp_pkg::ST_IDLE;
         cand_idx_ff <= '0;
         scan_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         cand_idx_ff <= cand_idx_in;
         scan_idx_ff <= scan_idx_in;
      end
   end

   // next state and controls
   always_comb begin
      state_in    = state_ff;
      cand_idx_in = cand_idx_ff;
      scan_idx_in = scan_idx_ff;
      rd_idx      = '0;
      ctl         = '0;
      unique case (state_ff)
         swp_pkg::ST_IDLE: begin
            if (start) begin
               ctl.start = 1'b1;
               state_in  = (count == '0) ? swp_pkg::ST_DONE : swp_pkg::ST_TGT_MUL;
            end
         end
         swp_pkg::ST_TGT_MUL: begin
            ctl.tgt_mul = 1'b1;
            state_in    = swp_pkg::ST_TGT_DIV;
         end
         swp_pkg::ST_TGT_DIV: begin
            ctl.tgt_div = 1'b1;
            cand_idx_in = '0;
            state_in    = swp_pkg::ST_CAND;
         end
         swp_pkg::ST_CAND: begin
            ctl.rd_en = 1'b1;
            rd_idx    = cand_idx_ff;
            state_in  = swp_pkg::ST_LOAD;
         end
         swp_pkg::ST_LOAD: begin
            // candidate data is here, start reading samples from slot zero
            ctl.load_cand = 1'b1;
            ctl.rd_en     = 1'b1;
            rd_idx        = '0;
            scan_idx_in   = CW'(1);
            state_in      = swp_pkg::ST_SCAN;
         end
         swp_pkg::ST_SCAN: begin
            // data in hand is slot scan_idx - 1
            ctl.count = 1'b1;
            if (scan_idx_ff == count) begin
               state_in = swp_pkg::ST_CHECK;
            end else begin
               ctl.rd_en   = 1'b1;
               rd_idx      = scan_idx_ff;
               scan_idx_in = scan_idx_ff + CW'(1);
            end
         end
         swp_pkg::ST_CHECK: begin
            ctl.check = 1'b1;
            if (cand_idx_ff + CW'(1) == count) begin
               state_in = swp_pkg::ST_DONE;
            end else begin
               ctl.rd_en   = 1'b1;
               rd_idx      = cand_idx_ff + CW'(1);
               cand_idx_in = cand_idx_ff + CW'(1);
               state_in    = swp_pkg::ST_LOAD;
            end
         end
         swp_pkg::ST_DONE: begin
            if (rsp_free) begin
               ctl.done_load = 1'b1;
               state_in      = swp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rd_addr = rd_idx[AW-1:0];
   assign idle    = (state_ff == swp_pkg::ST_IDLE);

endmodule
